// ----- hdl/scac_pkg.sv -----
// shared constants, types and codes of the set-associative read cache
// no dependencies; the interfaces, the cache top and scac_lookup refer to it by scoped names
`default_nettype none

package scac_pkg;

    localparam int ADDR_W  = 10;
    localparam int DATA_W  = 8;
    localparam int TOTAL_W = 32;

    // defaults for the top-level parameters, all powers of two
    localparam int MEM_BYTES   = 1024;
    localparam int BLOCK_BYTES = 4;
    localparam int SET_COUNT   = 4;
    localparam int WAY_COUNT   = 4;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_HIT_RD,
        S_FILL,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic hit;
        logic evict;
    } t_lkp;

endpackage

`default_nettype wire

// ----- hdl/scac_req_if.sv -----
// request channel of the cache: valid/ready handshake and one access item
// depends on scac_pkg for field widths
`default_nettype none

interface scac_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [scac_pkg::ADDR_W-1:0]  address;
    logic [scac_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, func, address, write_data, input ready);
    modport sink   (input valid, func, address, write_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/scac_rsp_if.sv -----
// response channel of the cache: valid/ready handshake and one result item
// depends on scac_pkg for field widths
`default_nettype none

interface scac_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [scac_pkg::DATA_W-1:0]   read_data;
    logic                          hit;
    logic [scac_pkg::TOTAL_W-1:0]  hit_total;
    logic [scac_pkg::TOTAL_W-1:0]  miss_total;

    modport source (output valid, read_data, hit, hit_total, miss_total, input ready);
    modport sink   (input valid, read_data, hit, hit_total, miss_total, output ready);
endinterface

`default_nettype wire

// ----- hdl/set_assoc_cache_fifo_read.sv -----
// set-associative read cache with round-robin replacement over a byte backing ram
// load: one item per cycle when idle. read hit: lookup, line read, result, output reg
// read miss: lookup, then a line fill bound by the byte-wide backing ram read port
// the next item is accepted once the current one reaches the output register
// reset clears counters and per-set row valid bits; no clearing pass
// depends on scac_pkg, scac_req_if, scac_rsp_if, scac_ram, scac_lookup
`default_nettype none

module set_assoc_cache_fifo_read #(
    parameter int MEM_BYTES   = scac_pkg::MEM_BYTES,
    parameter int BLOCK_BYTES = scac_pkg::BLOCK_BYTES,
    parameter int SET_COUNT   = scac_pkg::SET_COUNT,
    parameter int WAY_COUNT   = scac_pkg::WAY_COUNT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    scac_req_if.sink   i_req,
    scac_rsp_if.source o_rsp
);

    localparam int MEM_W    = $clog2(MEM_BYTES);
    localparam int OFF_B    = $clog2(BLOCK_BYTES);
    localparam int OFF_W    = (OFF_B > 0) ? OFF_B : 1;
    localparam int SET_B    = $clog2(SET_COUNT);
    localparam int SET_W    = (SET_B > 0) ? SET_B : 1;
    localparam int WAY_B    = $clog2(WAY_COUNT);
    localparam int WAY_W    = (WAY_B > 0) ? WAY_B : 1;
    localparam int CNT_W    = $clog2(WAY_COUNT + 1);
    localparam int TAG_B    = MEM_W - OFF_B - SET_B;
    localparam int TAG_W    = (TAG_B > 0) ? TAG_B : 1;
    localparam int ROW_W    = WAY_COUNT * TAG_W + WAY_W + CNT_W;
    localparam int LD_DEPTH = SET_COUNT * WAY_COUNT * BLOCK_BYTES;
    localparam int LD_W     = (LD_DEPTH > 1) ? $clog2(LD_DEPTH) : 1;
    localparam int FILL_W   = $clog2(BLOCK_BYTES + 1);
    localparam int DW       = scac_pkg::DATA_W;
    localparam int TW       = scac_pkg::TOTAL_W;

    scac_pkg::t_state r_state, n_state;

    logic [MEM_W-1:0]  r_addr;
    logic [WAY_W-1:0]  r_way;
    logic [FILL_W-1:0] r_fill;
    logic [DW-1:0]     r_byte;
    logic              r_hit;
    logic [TW-1:0]     r_hit_cnt;
    logic [TW-1:0]     r_miss_cnt;
    logic [SET_COUNT-1:0] r_row_vld;

    logic          r_out_valid;
    logic [DW-1:0] r_out_data;
    logic          r_out_hit;
    logic [TW-1:0] r_out_htot;
    logic [TW-1:0] r_out_mtot;

    logic [MEM_W-1:0] in_addr;
    logic [SET_W-1:0] in_set;
    logic [SET_W-1:0] cur_set;
    logic [OFF_W-1:0] cur_off;
    logic [TAG_W-1:0] cur_tag;
    logic [MEM_W-1:0] fill_addr;
    logic [OFF_W-1:0] fill_off;
    logic             in_fire;
    logic             load_fire;
    logic             out_free;

    logic [ROW_W-1:0] tag_rdata;
    logic [ROW_W-1:0] tag_wdata;
    logic             tag_we;
    scac_pkg::t_lkp   lk_flags;
    logic [WAY_W-1:0] lk_way;
    logic [CNT_W-1:0] lk_count;

    logic [DW-1:0]    bk_rdata;
    logic [DW-1:0]    ld_rdata;
    logic             ld_we;
    logic [LD_W-1:0]  ld_waddr;
    logic [LD_W-1:0]  ld_raddr;

    function automatic logic [LD_W-1:0] line_byte(
        input logic [SET_W-1:0] set_idx,
        input logic [WAY_W-1:0] way_idx,
        input logic [OFF_W-1:0] off_idx
    );
        line_byte = (LD_W'(set_idx) << (WAY_B + OFF_B)) | (LD_W'(way_idx) << OFF_B)
                  | LD_W'(off_idx);
    endfunction

    // address split
    assign in_addr   = MEM_W'(i_req.address);
    assign in_set    = SET_W'((in_addr >> OFF_B) & MEM_W'(SET_COUNT - 1));
    assign cur_set   = SET_W'((r_addr >> OFF_B) & MEM_W'(SET_COUNT - 1));
    assign cur_off   = OFF_W'(r_addr & MEM_W'(BLOCK_BYTES - 1));
    assign cur_tag   = TAG_W'(r_addr >> (OFF_B + SET_B));
    assign fill_addr = (r_addr & ~MEM_W'(BLOCK_BYTES - 1)) + MEM_W'(r_fill);
    assign fill_off  = OFF_W'(r_fill - FILL_W'(1));

    assign in_fire   = i_req.valid && i_req.ready;
    assign load_fire = in_fire && (i_req.func == scac_pkg::FUNC_LOAD);
    assign out_free  = !r_out_valid || o_rsp.ready;

    scac_ram #(.WIDTH(DW), .DEPTH(MEM_BYTES)) u_backing (
        .i_clk   (i_clk),
        .i_we    (load_fire),
        .i_waddr (in_addr),
        .i_wdata (i_req.write_data),
        .i_raddr (fill_addr),
        .o_rdata (bk_rdata)
    );

    scac_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_tags (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (cur_set),
        .i_wdata (tag_wdata),
        .i_raddr (in_set),
        .o_rdata (tag_rdata)
    );

    scac_ram #(.WIDTH(DW), .DEPTH(LD_DEPTH)) u_lines (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (ld_waddr),
        .i_wdata (bk_rdata),
        .i_raddr (ld_raddr),
        .o_rdata (ld_rdata)
    );

    scac_lookup #(.WAY_COUNT(WAY_COUNT), .TAG_W(TAG_W)) u_lookup (
        .i_row       (tag_rdata),
        .i_row_valid (r_row_vld[cur_set]),
        .i_tag       (cur_tag),
        .o_flags     (lk_flags),
        .o_way       (lk_way),
        .o_count     (lk_count),
        .o_row       (tag_wdata)
    );

    assign ld_raddr = line_byte(cur_set, lk_way, cur_off);
    assign ld_waddr = line_byte(cur_set, r_way, fill_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scac_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        tag_we      = 1'b0;
        ld_we       = 1'b0;
        case (r_state)
            scac_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid && (i_req.func == scac_pkg::FUNC_READ)) begin
                    n_state = scac_pkg::S_LOOKUP;
                end
            end
            scac_pkg::S_LOOKUP: begin
                if (lk_flags.hit) begin
                    n_state = scac_pkg::S_HIT_RD;
                end else begin
                    tag_we  = 1'b1;
                    n_state = scac_pkg::S_FILL;
                end
            end
            scac_pkg::S_HIT_RD: begin
                n_state = scac_pkg::S_RESULT;
            end
            scac_pkg::S_FILL: begin
                ld_we = (r_fill != '0);
                if (r_fill == FILL_W'(BLOCK_BYTES)) begin
                    n_state = scac_pkg::S_RESULT;
                end
            end
            scac_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = scac_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scac_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            if (r_state == scac_pkg::S_LOOKUP) begin
                if (lk_flags.hit) begin
                    r_hit_cnt <= r_hit_cnt + TW'(1);
                end else begin
                    r_miss_cnt         <= r_miss_cnt + TW'(1);
                    r_row_vld[cur_set] <= 1'b1;
                end
                r_fill <= '0;
            end else if (r_state == scac_pkg::S_FILL && r_fill != FILL_W'(BLOCK_BYTES)) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (r_state == scac_pkg::S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_addr <= in_addr;
        end
        if (r_state == scac_pkg::S_LOOKUP) begin
            r_hit <= lk_flags.hit;
            r_way <= lk_way;
        end
        if (r_state == scac_pkg::S_HIT_RD) begin
            r_byte <= ld_rdata;
        end
        if (ld_we && fill_off == cur_off) begin
            r_byte <= bk_rdata;
        end
        if (r_state == scac_pkg::S_RESULT && out_free) begin
            r_out_data <= r_byte;
            r_out_hit  <= r_hit;
            r_out_htot <= r_hit_cnt;
            r_out_mtot <= r_miss_cnt;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_data  = r_out_data;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.hit_total  = r_out_htot;
    assign o_rsp.miss_total = r_out_mtot;

    a_miss_only_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != scac_pkg::S_LOOKUP) |=> $stable(r_miss_cnt))
        else $error("miss counter moved outside lookup");

    a_read_goes_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.func == scac_pkg::FUNC_READ) |=> (r_state == scac_pkg::S_LOOKUP))
        else $error("accepted read did not start lookup");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scac_pkg::S_LOOKUP) |-> (lk_count <= CNT_W'(WAY_COUNT)))
        else $error("set fill count beyond way count");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scac_pkg::S_RESULT && out_free) |=> r_out_valid)
        else $error("result not posted to output register");

    a_miss_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scac_pkg::S_LOOKUP && !lk_flags.hit) |=>
        (r_state == scac_pkg::S_FILL && r_fill == '0 && r_row_vld[cur_set]))
        else $error("miss did not start a line fill");

endmodule

`default_nettype wire

// ----- hdl/scac_ram.sv -----
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module scac_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/scac_lookup.sv -----
// tag compare and victim choice over one set row {fill count, fifo pointer, tags}
// depends on scac_pkg for the lookup flag struct
`default_nettype none

module scac_lookup #(
    parameter  int WAY_COUNT = scac_pkg::WAY_COUNT,
    parameter  int TAG_W     = 6,
    localparam int WAY_B     = $clog2(WAY_COUNT),
    localparam int WAY_W     = (WAY_B > 0) ? WAY_B : 1,
    localparam int CNT_W     = $clog2(WAY_COUNT + 1),
    localparam int ROW_W     = WAY_COUNT * TAG_W + WAY_W + CNT_W
) (
    input  wire logic [ROW_W-1:0] i_row,
    input  wire logic             i_row_valid,
    input  wire logic [TAG_W-1:0] i_tag,
    output scac_pkg::t_lkp        o_flags,
    output logic      [WAY_W-1:0] o_way,
    output logic      [CNT_W-1:0] o_count,
    output logic      [ROW_W-1:0] o_row
);

    localparam int PTR_LSB = WAY_COUNT * TAG_W;
    localparam int CNT_LSB = PTR_LSB + WAY_W;

    logic [CNT_W-1:0] cnt;
    logic [WAY_W-1:0] ptr;
    logic [WAY_W-1:0] hit_way;
    logic             hit;
    logic [WAY_W-1:0] vic_way;
    logic             evict;

    assign cnt = i_row_valid ? i_row[CNT_LSB +: CNT_W] : '0;
    assign ptr = i_row_valid ? i_row[PTR_LSB +: WAY_W] : '0;

    // ways below the fill count are valid
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (!hit && (CNT_W'(w) < cnt) && (i_row[w*TAG_W +: TAG_W] == i_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        evict   = (cnt == CNT_W'(WAY_COUNT));
        vic_way = evict ? ptr : WAY_W'(cnt);
        o_row   = i_row;
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (vic_way == WAY_W'(w)) begin
                o_row[w*TAG_W +: TAG_W] = i_tag;
            end
        end
        if (evict) begin
            o_row[PTR_LSB +: WAY_W] = (ptr == WAY_W'(WAY_COUNT - 1)) ? '0 : ptr + WAY_W'(1);
            o_row[CNT_LSB +: CNT_W] = cnt;
        end else begin
            o_row[PTR_LSB +: WAY_W] = ptr;
            o_row[CNT_LSB +: CNT_W] = cnt + CNT_W'(1);
        end
    end

    assign o_flags.hit   = hit;
    assign o_flags.evict = evict;
    assign o_way         = hit ? hit_way : vic_way;
    assign o_count       = cnt;

endmodule

`default_nettype wire
